[rtl/audio_buffer_pool_manager_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the buffer pool manager.
// ----------------------------------------------------------------------------
`ifndef AUDIO_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH
`define AUDIO_BUFFER_POOL_MANAGER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define ABPM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("abpm assertion failed");

// next-cycle implication
`define ABPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("abpm assertion failed");

`endif

[rtl/abpm_pkg.sv]
// ----------------------------------------------------------------------------
// abpm_pkg
// Types and constants of the audio buffer pool manager.
// ----------------------------------------------------------------------------
package abpm_pkg;

	localparam int POOL_MAX_DEF = 16;
	localparam int ID_W         = 4;
	localparam int CNT_W        = 5;
	localparam int KIND_W       = 4;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 3;

	localparam logic [CNT_W-1:0] NUM_BUFS_RST = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		K_INIT       = 4'd0,
		K_PUSH_FREE  = 4'd1,
		K_PUSH_READY = 4'd2,
		K_TAKE_FREE  = 4'd3,
		K_TAKE_READY = 4'd4,
		K_START      = 4'd5,
		K_STOP       = 4'd6,
		K_POLL       = 4'd7,
		K_XFER_DONE  = 4'd8
	} kind_t;

	// register index of the buffer count
	localparam logic REG_NUM_BUFS = 1'b0;

	typedef struct packed {
		logic            clr;
		logic            push;
		logic            pop;
		logic [ID_W-1:0] wdata;
	} q_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] level;
		logic [ID_W-1:0]  head;
	} q_stat_t;

endpackage

[rtl/abpm_idq.sv]
// ----------------------------------------------------------------------------
// abpm_idq
// Buffer ID FIFO: memory with wrapping pointers, a level count and a
// registered head read.
// ----------------------------------------------------------------------------
module abpm_idq #(
	parameter int POOL_MAX = abpm_pkg::POOL_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  abpm_pkg::q_cmd_t cmd,
	output abpm_pkg::q_stat_t st
);

	localparam int PTR_W = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_MAX - 1);

	logic [abpm_pkg::ID_W-1:0]  mem [POOL_MAX];
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [abpm_pkg::CNT_W-1:0] level_q;
	logic [abpm_pkg::ID_W-1:0]  head_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_ptr_q] <= cmd.wdata;
		end
		head_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			level_q  <= '0;
		end else if (cmd.clr) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (cmd.pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			level_q <= level_q + abpm_pkg::CNT_W'(cmd.push) - abpm_pkg::CNT_W'(cmd.pop);
		end
	end

	assign st.level = level_q;
	assign st.head  = head_q;

endmodule

[rtl/abpm_cfg.sv]
// ----------------------------------------------------------------------------
// abpm_cfg
// APB register file: buffer count, and the queue capacity clamped to the pool.
// ----------------------------------------------------------------------------
module abpm_cfg #(
	parameter int POOL_MAX = abpm_pkg::POOL_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [abpm_pkg::ADDR_W-1:0] paddr,
	input  logic [abpm_pkg::DATA_W-1:0] pwdata,
	output logic [abpm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic [abpm_pkg::CNT_W-1:0]  cap
);

	// levels never exceed the 5-bit buffer count, so the clamp fits CNT_W
	localparam int CAP_LIM_I = (POOL_MAX > 31) ? 31 : POOL_MAX;
	localparam logic [abpm_pkg::CNT_W-1:0] CAP_LIM = abpm_pkg::CNT_W'(CAP_LIM_I);

	logic [abpm_pkg::CNT_W-1:0] num_bufs_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == abpm_pkg::REG_NUM_BUFS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bufs_q <= abpm_pkg::NUM_BUFS_RST;
		end else if (wr_en) begin
			num_bufs_q <= pwdata[abpm_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == abpm_pkg::REG_NUM_BUFS) begin
			prdata = abpm_pkg::DATA_W'(num_bufs_q);
		end
	end

	assign cap = (num_bufs_q > CAP_LIM) ? CAP_LIM : num_bufs_q;

endmodule

[rtl/audio_buffer_pool_manager_unit.sv]
// ----------------------------------------------------------------------------
// audio_buffer_pool_manager_unit
// Free/ready buffer ID queue manager with a streaming sequencer.
//
// Input channel (in_valid/in_stall) carries one event: kind and buffer_id.
// Output channel (out_valid/out_stall) returns one result per event.
// The sequencer takes one event at a time; in_stall is high from the
// cycle after a transaction until its result is loaded.
// Most events pass from idle through the execute step to the final step, which
// loads their result into the output register; no new event is taken before that load.
// Init: clears both queues, then writes IDs 0 to capacity - 1 into the free queue, one ID per cycle.
// Stop: drains the ready queue into the free queue, one entry per move (each move waits
// for the registered head read of the ready queue memory).
// A result waits in the output register while out_stall is high; the
// sequencer holds in its final step until the register is free.
// Reset empties both queues, clears streaming state, buffer count = 16.
// Users must write the buffer count over APB (address 0) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module audio_buffer_pool_manager_unit #(
	parameter int POOL_MAX = abpm_pkg::POOL_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [abpm_pkg::KIND_W-1:0] kind,
	input  logic [abpm_pkg::ID_W-1:0]   buffer_id,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        accepted,
	output logic [abpm_pkg::ID_W-1:0]   out_buffer_id,
	output logic                        start_transfer,
	output logic [abpm_pkg::CNT_W-1:0]  free_count,
	output logic [abpm_pkg::CNT_W-1:0]  ready_count,
	output logic                        streaming,
	output logic                        transfer_busy,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [abpm_pkg::ADDR_W-1:0] paddr,
	input  logic [abpm_pkg::DATA_W-1:0] pwdata,
	output logic [abpm_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_FILL  = 6'b000100,
		S_DMOVE = 6'b001000,
		S_DWAIT = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t                     state_q, state_d;
	logic [abpm_pkg::KIND_W-1:0] kind_q, kind_d;
	logic [abpm_pkg::ID_W-1:0]  bid_q, bid_d;
	logic                       acc_q, acc_d;
	logic [abpm_pkg::ID_W-1:0]  oid_q, oid_d;
	logic                       st_q, st_d;
	logic [abpm_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                       loaded_q, loaded_d;
	logic                       stream_q, stream_d;
	logic                       busy_q, busy_d;
	logic [abpm_pkg::ID_W-1:0]  cur_q, cur_d;
	logic                       held_q, held_d;
	logic                       do_launch;
	logic                       out_load;

	logic [abpm_pkg::CNT_W-1:0] cap;
	abpm_pkg::q_cmd_t           fq_cmd, rq_cmd;
	abpm_pkg::q_stat_t          fq_st, rq_st;

	abpm_cfg #(.POOL_MAX(POOL_MAX)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap)
	);

	abpm_idq #(.POOL_MAX(POOL_MAX)) u_free_q (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fq_cmd),
		.st     (fq_st)
	);

	abpm_idq #(.POOL_MAX(POOL_MAX)) u_ready_q (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rq_cmd),
		.st     (rq_st)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid || !out_stall);

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		bid_d     = bid_q;
		acc_d     = acc_q;
		oid_d     = oid_q;
		st_d      = st_q;
		cnt_d     = cnt_q;
		loaded_d  = loaded_q;
		stream_d  = stream_q;
		busy_d    = busy_q;
		cur_d     = cur_q;
		held_d    = held_q;
		do_launch = 1'b0;
		fq_cmd    = '0;
		rq_cmd    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					kind_d  = kind;
					bid_d   = buffer_id;
					acc_d   = 1'b0;
					oid_d   = '0;
					st_d    = 1'b0;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				case (abpm_pkg::kind_t'(kind_q))
					abpm_pkg::K_INIT: begin
						fq_cmd.clr = 1'b1;
						rq_cmd.clr = 1'b1;
						loaded_d   = 1'b1;
						cnt_d      = '0;
						state_d    = S_FILL;
					end
					abpm_pkg::K_PUSH_FREE: begin
						if (loaded_q && (fq_st.level < cap)) begin
							fq_cmd.push  = 1'b1;
							fq_cmd.wdata = bid_q;
							acc_d        = 1'b1;
						end
					end
					abpm_pkg::K_PUSH_READY: begin
						if (loaded_q && (rq_st.level < cap)) begin
							rq_cmd.push  = 1'b1;
							rq_cmd.wdata = bid_q;
							acc_d        = 1'b1;
						end
					end
					abpm_pkg::K_TAKE_FREE: begin
						if (fq_st.level != '0) begin
							fq_cmd.pop = 1'b1;
							acc_d      = 1'b1;
							oid_d      = fq_st.head;
						end
					end
					abpm_pkg::K_TAKE_READY: begin
						if (rq_st.level != '0) begin
							rq_cmd.pop = 1'b1;
							acc_d      = 1'b1;
							oid_d      = rq_st.head;
						end
					end
					abpm_pkg::K_START: begin
						if (loaded_q) begin
							stream_d  = 1'b1;
							do_launch = !busy_q;
						end
					end
					abpm_pkg::K_POLL: begin
						do_launch = stream_q && !busy_q;
					end
					abpm_pkg::K_STOP: begin
						if (stream_q) begin
							stream_d = 1'b0;
							state_d  = S_DMOVE;
						end
					end
					abpm_pkg::K_XFER_DONE: begin
						if (busy_q) begin
							if (held_q && (fq_st.level < cap)) begin
								fq_cmd.push  = 1'b1;
								fq_cmd.wdata = cur_q;
							end
							held_d = 1'b0;
							if (stream_q) begin
								do_launch = 1'b1;
							end else begin
								busy_d = 1'b0;
							end
						end
					end
					default: begin
					end
				endcase

				// next ready ID goes out, or the transfer side goes idle
				if (do_launch) begin
					if (rq_st.level != '0) begin
						rq_cmd.pop = 1'b1;
						busy_d     = 1'b1;
						cur_d      = rq_st.head;
						held_d     = 1'b1;
						st_d       = 1'b1;
						oid_d      = rq_st.head;
					end else begin
						busy_d = 1'b0;
					end
				end
			end
			S_FILL: begin
				if (cnt_q < cap) begin
					fq_cmd.push  = 1'b1;
					fq_cmd.wdata = cnt_q[abpm_pkg::ID_W-1:0];
					cnt_d        = cnt_q + 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DMOVE: begin
				if (rq_st.level == '0) begin
					state_d = S_FIN;
				end else begin
					rq_cmd.pop = 1'b1;
					if (fq_st.level < cap) begin
						fq_cmd.push  = 1'b1;
						fq_cmd.wdata = rq_st.head;
					end
					state_d = S_DWAIT;
				end
			end
			S_DWAIT: begin
				// head register catches up with the new read pointer
				state_d = S_DMOVE;
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			loaded_q <= 1'b0;
			stream_q <= 1'b0;
			busy_q   <= 1'b0;
			cur_q    <= '0;
			held_q   <= 1'b0;
			cnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			loaded_q <= loaded_d;
			stream_q <= stream_d;
			busy_q   <= busy_d;
			cur_q    <= cur_d;
			held_q   <= held_d;
			cnt_q    <= cnt_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		bid_q  <= bid_d;
		acc_q  <= acc_d;
		oid_q  <= oid_d;
		st_q   <= st_d;
		if (out_load) begin
			accepted       <= acc_q;
			out_buffer_id  <= oid_q;
			start_transfer <= st_q;
			free_count     <= fq_st.level;
			ready_count    <= rq_st.level;
			streaming      <= stream_q;
			transfer_busy  <= busy_q;
		end
	end

endmodule

[rtl/abpm_checker.sv]
// ----------------------------------------------------------------------------
// abpm_checker
// Port-level checks of the buffer pool manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_buffer_pool_manager_unit_macros.svh"

module abpm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      accepted,
	input logic [abpm_pkg::ID_W-1:0] out_buffer_id,
	input logic                      start_transfer,
	input logic                      streaming,
	input logic                      transfer_busy
);

	// a held result keeps its ID
	`ABPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_buffer_id))

	// one event at a time: the sequencer blocks right after a transaction
	`ABPM_ASSERT_NEXT(a_in_block, in_valid && !in_stall, in_stall)

	// a launch is never also a push or take result
	`ABPM_ASSERT_IMPL(a_launch_excl, out_valid && start_transfer, !accepted)

	// a launch leaves the block streaming with a transfer running
	`ABPM_ASSERT_IMPL(a_launch_busy, out_valid && start_transfer, streaming && transfer_busy)

endmodule

bind audio_buffer_pool_manager_unit abpm_checker u_abpm_checker (.*);

[sim/tb_audio_buffer_pool_manager_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_buffer_pool_manager_unit
// Self-checking bench for the free/ready buffer ID queue manager. A queue fed
// driver offers events on the input channel, a clocked monitor predicts the
// status of each accepted event and compares every returned result with it.
// The buffer count is reprogrammed over APB between phases with different
// sender idle and receiver stall rates, one phase with a long output hold.
// ----------------------------------------------------------------------------
module tb_audio_buffer_pool_manager_unit;

	localparam int KIND_W   = abpm_pkg::KIND_W;
	localparam int ID_W     = abpm_pkg::ID_W;
	localparam int CNT_W    = abpm_pkg::CNT_W;
	localparam int ADDR_W   = abpm_pkg::ADDR_W;
	localparam int DATA_W   = abpm_pkg::DATA_W;
	localparam int POOL_MAX = abpm_pkg::POOL_MAX_DEF;

	localparam int PHASE_EVENTS = 86;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 60;
	localparam logic [ADDR_W-1:0] NUM_BUFS_ADDR = ADDR_W'(4 * int'(abpm_pkg::REG_NUM_BUFS));

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
	} pool_event_t;

	typedef struct {
		logic             acc;
		logic [ID_W-1:0]  oid;
		logic             start;
		logic [CNT_W-1:0] free_lvl;
		logic [CNT_W-1:0] ready_lvl;
		logic             strm;
		logic             busy;
	} pool_status_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [KIND_W-1:0]   kind      = '0;
	logic [ID_W-1:0]     buffer_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                accepted;
	logic [ID_W-1:0]     out_buffer_id;
	logic                start_transfer;
	logic [CNT_W-1:0]    free_count;
	logic [CNT_W-1:0]    ready_count;
	logic                streaming;
	logic                transfer_busy;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// event stream and expected status
	pool_event_t  pending_events[$];
	pool_status_t expected_status[$];
	pool_status_t head_status;
	pool_event_t  next_event;
	int unsigned  events_queued = 0;
	int unsigned  events_taken  = 0;
	int unsigned  results_seen  = 0;
	int unsigned  mismatches    = 0;
	int unsigned  cfg_errors    = 0;
	int unsigned  cfg_writes    = 0;
	int unsigned  xfers_started = 0;
	int unsigned  ids_moved     = 0;
	bit           in_fire       = 1'b0;

	// idling control
	int unsigned  send_idle_pct = 0;
	int unsigned  stall_pct     = 0;
	int unsigned  hold_reqs     = 0;
	int unsigned  hold_served   = 0;
	int unsigned  hold_left     = 0;

	// predicted block state
	logic [CNT_W-1:0] cfg_num_bufs  = abpm_pkg::NUM_BUFS_RST;
	logic [ID_W-1:0]  free_ids[$];
	logic [ID_W-1:0]  ready_ids[$];
	bit               pool_ready_m  = 1'b0;
	bit               stream_m      = 1'b0;
	bit               busy_m        = 1'b0;
	bit               held_m        = 1'b0;
	logic [ID_W-1:0]  playing_id    = '0;

	audio_buffer_pool_manager_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.buffer_id      (buffer_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.accepted       (accepted),
		.out_buffer_id  (out_buffer_id),
		.start_transfer (start_transfer),
		.free_count     (free_count),
		.ready_count    (ready_count),
		.streaming      (streaming),
		.transfer_busy  (transfer_busy),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #2 clk = ~clk;

	// ---------------- buffer pool predictor ----------------
	function automatic int queue_cap();
		return (int'(cfg_num_bufs) > POOL_MAX) ? POOL_MAX : int'(cfg_num_bufs);
	endfunction

	// begin playing the head of the ready queue, or go idle
	function automatic void start_next_ready(inout pool_status_t r);
		if (ready_ids.size() > 0) begin
			playing_id = ready_ids.pop_front();
			busy_m     = 1'b1;
			held_m     = 1'b1;
			r.start    = 1'b1;
			r.oid      = playing_id;
		end else begin
			busy_m = 1'b0;
		end
	endfunction

	function automatic pool_status_t apply_pool_event(logic [KIND_W-1:0] k,
			logic [ID_W-1:0] id);
		pool_status_t    r;
		logic [ID_W-1:0] v;
		int              cap;
		int              i;
		r   = '{default: '0};
		cap = queue_cap();
		case (k)
			abpm_pkg::K_INIT: begin
				free_ids.delete();
				ready_ids.delete();
				pool_ready_m = 1'b1;
				for (i = 0; i < cap; i++)
					free_ids.push_back(ID_W'(i));
			end
			abpm_pkg::K_PUSH_FREE: begin
				if (pool_ready_m && free_ids.size() < cap) begin
					free_ids.push_back(id);
					r.acc = 1'b1;
				end
			end
			abpm_pkg::K_PUSH_READY: begin
				if (pool_ready_m && ready_ids.size() < cap) begin
					ready_ids.push_back(id);
					r.acc = 1'b1;
				end
			end
			abpm_pkg::K_TAKE_FREE: begin
				if (free_ids.size() > 0) begin
					r.acc = 1'b1;
					r.oid = free_ids.pop_front();
				end
			end
			abpm_pkg::K_TAKE_READY: begin
				if (ready_ids.size() > 0) begin
					r.acc = 1'b1;
					r.oid = ready_ids.pop_front();
				end
			end
			abpm_pkg::K_START, abpm_pkg::K_POLL: begin
				// start before the first init is dropped; start while streaming polls
				if (!(k == abpm_pkg::K_START && !pool_ready_m)) begin
					if (k == abpm_pkg::K_START)
						stream_m = 1'b1;
					if (stream_m && !busy_m)
						start_next_ready(r);
				end
			end
			abpm_pkg::K_STOP: begin
				if (stream_m) begin
					stream_m = 1'b0;
					while (ready_ids.size() > 0) begin
						v = ready_ids.pop_front();
						if (free_ids.size() < cap)
							free_ids.push_back(v);
					end
				end
			end
			abpm_pkg::K_XFER_DONE: begin
				if (busy_m) begin
					if (held_m && free_ids.size() < cap)
						free_ids.push_back(playing_id);
					held_m = 1'b0;
					if (!stream_m)
						busy_m = 1'b0;
					else
						start_next_ready(r);
				end
			end
			default: ;
		endcase
		r.free_lvl  = CNT_W'(free_ids.size());
		r.ready_lvl = CNT_W'(ready_ids.size());
		r.strm      = stream_m;
		r.busy      = busy_m;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// ---------------- input driver ----------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_event = pending_events.pop_front();
				in_valid  <= 1'b1;
				kind      <= next_event.kind;
				buffer_id <= next_event.id;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- output stall, with long hold-offs on request ----------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_reqs != hold_served) begin
			hold_served++;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ---------------- monitor: predict on input, check on output ----------------
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) begin
			head_status = apply_pool_event(kind, buffer_id);
			expected_status.push_back(head_status);
			events_taken++;
			xfers_started += head_status.start;
			ids_moved     += head_status.acc;
		end
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_status.size() == 0) begin
				$error("result transaction with no event outstanding");
				mismatches++;
			end else begin
				head_status = expected_status.pop_front();
				check_field("accepted", head_status.acc, accepted);
				check_field("out_buffer_id", head_status.oid, out_buffer_id);
				check_field("start_transfer", head_status.start, start_transfer);
				check_field("free_count", head_status.free_lvl, free_count);
				check_field("ready_count", head_status.ready_lvl, ready_count);
				check_field("streaming", head_status.strm, streaming);
				check_field("transfer_busy", head_status.busy, transfer_busy);
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic queue_event(logic [KIND_W-1:0] k, logic [ID_W-1:0] id);
		pending_events.push_back('{kind: k, id: id});
		events_queued++;
	endtask

	function automatic logic [ID_W-1:0] rand_id();
		return ID_W'($urandom_range(15));
	endfunction

	function automatic logic [KIND_W-1:0] rand_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)  return abpm_pkg::K_INIT;
		if (r < 17) return abpm_pkg::K_PUSH_FREE;
		if (r < 37) return abpm_pkg::K_PUSH_READY;
		if (r < 52) return abpm_pkg::K_TAKE_FREE;
		if (r < 60) return abpm_pkg::K_TAKE_READY;
		if (r < 68) return abpm_pkg::K_START;
		if (r < 73) return abpm_pkg::K_STOP;
		if (r < 83) return abpm_pkg::K_POLL;
		if (r < 97) return abpm_pkg::K_XFER_DONE;
		return KIND_W'($urandom_range(int'(abpm_pkg::K_XFER_DONE) + 1, 15));
	endfunction

	function automatic logic [KIND_W-1:0] rand_stream_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35) return abpm_pkg::K_PUSH_READY;
		if (r < 65) return abpm_pkg::K_XFER_DONE;
		if (r < 75) return abpm_pkg::K_POLL;
		if (r < 85) return abpm_pkg::K_PUSH_FREE;
		return abpm_pkg::K_TAKE_FREE;
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (!(events_taken == events_queued && results_seen == events_taken));
	endtask

	task automatic apb_access(bit wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_num_bufs(logic [CNT_W-1:0] size);
		logic [DATA_W-1:0] rd;
		apb_access(1'b1, NUM_BUFS_ADDR, DATA_W'(size), rd);
		cfg_num_bufs = size;
		cfg_writes++;
		apb_access(1'b0, NUM_BUFS_ADDR, '0, rd);
		if (rd[CNT_W-1:0] !== size) begin
			$error("num_bufs readback: expected %0d, got %0d", size, rd[CNT_W-1:0]);
			cfg_errors++;
		end
	endtask

	// streaming sessions mostly, noise in between
	task automatic run_phase(logic [CNT_W-1:0] size, int unsigned idle_pct,
			int unsigned stl_pct, bit long_hold);
		int n;
		int m;
		n = 0;
		set_num_bufs(size);
		send_idle_pct = idle_pct;
		stall_pct     = stl_pct;
		if (long_hold)
			hold_reqs++;
		while (n < PHASE_EVENTS) begin
			if ($urandom_range(9) < 7) begin
				m = $urandom_range(4, 12);
				queue_event(abpm_pkg::K_START, rand_id());
				repeat (m) queue_event(rand_stream_kind(), rand_id());
				queue_event(abpm_pkg::K_STOP, rand_id());
				n += m + 2;
			end else begin
				queue_event(rand_kind(), rand_id());
				n++;
			end
		end
		wait_idle();
	endtask

	initial begin
		logic [DATA_W-1:0] rd;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		apb_access(1'b0, NUM_BUFS_ADDR, '0, rd);
		if (rd[CNT_W-1:0] !== abpm_pkg::NUM_BUFS_RST) begin
			$error("num_bufs after reset: expected %0d, got %0d", abpm_pkg::NUM_BUFS_RST,
				rd[CNT_W-1:0]);
			cfg_errors++;
		end

		// directed: pool not loaded yet, empty queues, idle stop/poll/done
		queue_event(abpm_pkg::K_PUSH_FREE, 4'd5);
		queue_event(abpm_pkg::K_START, 4'd0);
		queue_event(abpm_pkg::K_TAKE_FREE, 4'd0);
		queue_event(abpm_pkg::K_TAKE_READY, 4'd15);
		queue_event(abpm_pkg::K_STOP, 4'd0);
		queue_event(abpm_pkg::K_POLL, 4'd0);
		queue_event(abpm_pkg::K_XFER_DONE, 4'd0);
		queue_event(4'hF, 4'hF);
		queue_event(abpm_pkg::K_INIT, 4'd0);
		queue_event(abpm_pkg::K_PUSH_FREE, 4'd15);     // free queue full
		queue_event(abpm_pkg::K_PUSH_READY, 4'd0);
		queue_event(abpm_pkg::K_PUSH_READY, 4'd15);
		queue_event(abpm_pkg::K_PUSH_READY, 4'd9);
		queue_event(abpm_pkg::K_START, 4'd0);
		queue_event(abpm_pkg::K_START, 4'd0);          // already streaming, busy
		queue_event(abpm_pkg::K_POLL, 4'd0);
		queue_event(abpm_pkg::K_XFER_DONE, 4'd0);      // finished ID dropped, next chained
		queue_event(abpm_pkg::K_STOP, 4'd0);           // drained ID dropped, transfer keeps going
		queue_event(abpm_pkg::K_XFER_DONE, 4'd0);
		queue_event(abpm_pkg::K_TAKE_FREE, 4'd0);
		queue_event(abpm_pkg::K_TAKE_FREE, 4'd0);
		queue_event(abpm_pkg::K_START, 4'd0);
		queue_event(abpm_pkg::K_INIT, 4'd0);           // rebuild while streaming
		queue_event(abpm_pkg::K_TAKE_READY, 4'd0);
		queue_event(4'd9, 4'd10);
		wait_idle();

		run_phase(5'd1, 0, 0, 1'b0);
		run_phase(5'd0, 85, 0, 1'b0);
		run_phase(5'd31, 0, 85, 1'b0);
		run_phase(5'd16, 10, 10, 1'b0);
		run_phase(CNT_W'($urandom_range(1, 16)), 0, 0, 1'b1);
		run_phase(CNT_W'($urandom_range(0, 31)), 85, 0, 1'b0);
		run_phase(5'd8, 0, 85, 1'b0);
		run_phase(5'd16, 10, 10, 1'b0);

		// catch any stray result after the last one
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d events across %0d buffer-count settings, incl. 0, 1, 8, 16, 31.",
			events_taken, cfg_writes);
		$display("%0d pushes/takes accepted, %0d transfers started, %0d errors.",
			ids_moved, xfers_started, mismatches + cfg_errors);
		if (mismatches == 0 && cfg_errors == 0 && expected_status.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
